### hw/rtl/scalar_rls_steer_offset_core_defines.svh
// Assertion macros for the steering offset estimator core.
`ifndef SCALAR_RLS_STEER_OFFSET_CORE_DEFINES_SVH
`define SCALAR_RLS_STEER_OFFSET_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked at every clock edge outside reset.
`define SRSO_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SRSO_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define SRSO_ASSERT(lbl, prop, msg)
`define SRSO_ASSERT_RST(lbl, prop, msg)

`endif

`endif

### hw/rtl/srso_pkg.sv
// Shared types, widths and codes for the steering offset estimator.
`timescale 1ns / 1ps

package srso_pkg;

   // Q16.16 data, Q1.16 forgetting factor
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;

   // configuration register widths
   localparam int WB_W   = 31;
   localparam int FF_W   = 17;
   localparam int MS_W   = 31;
   localparam int MX_W   = 31;
   localparam int COV_W  = 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_BASE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORGET_FACTOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEER     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_COV   = 3'd4;

   localparam logic [WB_W-1:0]  WB_RST   = 31'd18678;
   localparam logic [FF_W-1:0]  FF_RST   = 17'd65470;
   localparam logic [MS_W-1:0]  MS_RST   = 31'd18678;
   localparam logic [MX_W-1:0]  MX_RST   = 31'd3277;
   localparam logic [COV_W-1:0] ICOV_RST = 32'd65536000;

   localparam logic [FF_W-1:0]  FF_ONE   = 17'd65536;

   // internal datapath widths
   localparam int P_W    = 31;   // |phi|, saturated to signed max
   localparam int Q_W    = 46;   // phi^2
   localparam int G_W    = 62;   // phi^2 * P
   localparam int DEN_W  = 63;   // lambda + g
   localparam int K_W    = 63;   // gain magnitude
   localparam int E_W    = 49;   // innovation magnitude
   localparam int D_W    = 63;   // offset step magnitude
   localparam int MOP_W  = 33;   // multiplier operand
   localparam int PROD_W = 66;   // multiplier product
   localparam int ACC_W  = 112;  // partial product accumulator
   localparam int DIV_W  = 64;   // divider operand width

   localparam logic [P_W-1:0]    P_MAX   = 31'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] U32_MAX = 32'hFFFF_FFFF;
   localparam logic [D_W-1:0]    MID_CAP = 63'h4000_0000_0000_0000;

   // multiplier operand selects
   localparam logic [3:0] MUL_IDLE  = 4'd0;
   localparam logic [3:0] MUL_PP    = 4'd1;
   localparam logic [3:0] MUL_QL_P  = 4'd2;
   localparam logic [3:0] MUL_QH_P  = 4'd3;
   localparam logic [3:0] MUL_P_COV = 4'd4;
   localparam logic [3:0] MUL_P_A   = 4'd5;
   localparam logic [3:0] MUL_K0_E0 = 4'd6;
   localparam logic [3:0] MUL_K0_E1 = 4'd7;
   localparam logic [3:0] MUL_K1_E0 = 4'd8;
   localparam logic [3:0] MUL_K1_E1 = 4'd9;

   // accumulator operations and shifts (in 32-bit words)
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_CLR  = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   localparam logic [1:0] SH_W0 = 2'd0;
   localparam logic [1:0] SH_W1 = 2'd1;
   localparam logic [1:0] SH_W2 = 2'd2;

   // divider operand selects
   localparam logic [1:0] DIV_SPEED = 2'd0;
   localparam logic [1:0] DIV_GAIN  = 2'd1;
   localparam logic [1:0] DIV_COV   = 2'd2;

   typedef struct packed {
      logic                     samples_present;
      logic signed [DATA_W-1:0] velocity;
      logic signed [DATA_W-1:0] yaw_rate;
      logic signed [DATA_W-1:0] steer_angle;
   } srso_req_type;

   typedef struct packed {
      logic                     updated;
      logic signed [DATA_W-1:0] offset_estimate;
      logic [DATA_W-1:0]        covariance_out;
   } srso_rsp_type;

   typedef struct packed {
      logic       load_in;
      logic       ld_ok;
      logic       ld_p;
      logic       ld_q;
      logic       ld_den;
      logic       ld_k;
      logic       ld_newp;
      logic       ld_e;
      logic       commit;
      logic [3:0] mul_sel;
      logic [1:0] acc_op;
      logic [1:0] acc_sh;
      logic       div_start;
      logic [1:0] div_sel;
   } srso_cmd_type;

   typedef struct packed {
      logic ok;
      logic div_done;
      logic div_busy;
   } srso_stat_type;

endpackage

### hw/rtl/srso_div.sv
// Radix-2 restoring divider, one quotient bit per clock.
`timescale 1ns / 1ps

module srso_div import srso_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             busy,
   output logic             done
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DIV_W:0]   rem_sh;
   logic             ge;

   assign rem_sh = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

### hw/rtl/srso_dpath.sv
// Datapath: config registers, estimator state, shared multiplier, accumulator and divider.
`timescale 1ns / 1ps

module srso_dpath import srso_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  srso_req_type          req_payload,
   input  srso_cmd_type          cmd,
   output srso_stat_type         stat,
   output srso_rsp_type          rsp_payload
);

   // configuration
   logic [WB_W-1:0]  wb_ff;
   logic [FF_W-1:0]  ff_ff;
   logic [MS_W-1:0]  ms_ff;
   logic [MX_W-1:0]  mx_ff;

   // estimator state
   logic [DATA_W-1:0] off_ff;
   logic [COV_W-1:0]  cov_ff;

   // per-request working registers
   srso_req_type      in_ff;
   logic              ok_ff;
   logic [P_W-1:0]    p_ff;
   logic [Q_W-1:0]    q_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [K_W-1:0]    k_ff;
   logic [COV_W-1:0]  newp_ff;
   logic [E_W-1:0]    e_ff;
   logic              eneg_ff;
   logic [PROD_W-1:0] mul_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   srso_rsp_type      rsp_ff;

   logic [DATA_W-1:0] vel_u, steer_u, vmag, smag;
   logic              vneg, ok;
   logic [WB_W-1:0]   wb_eff;
   logic [FF_W-1:0]   lam;

   logic [MOP_W-1:0]  mop_a, mop_b;
   logic [ACC_W-1:0]  pp_sh;

   logic [DIV_W-1:0]  div_dvd, div_dvs, div_quo;
   logic              div_busy, div_done;

   logic [G_W-1:0]    g;
   logic [DEN_W-1:0]  den_in;

   logic [DATA_W:0]   a_s, amag;
   logic [47:0]       t;
   logic [49:0]       t_ext, ts, e_s, e_abs;
   logic              ts_neg;

   logic [D_W-1:0]    d;
   logic [63:0]       d_ext, ds, noff;
   logic              ovf;
   logic [DATA_W-1:0] noff_sat;

   // request decode and validity check
   assign vel_u   = in_ff.velocity;
   assign steer_u = in_ff.steer_angle;
   assign vneg    = vel_u[DATA_W-1];
   assign vmag    = vneg ? (~vel_u + 32'd1) : vel_u;
   assign smag    = steer_u[DATA_W-1] ? (~steer_u + 32'd1) : steer_u;
   assign ok      = in_ff.samples_present && (vmag >= {1'b0, ms_ff})
                    && (smag <= {1'b0, mx_ff});

   assign wb_eff = (wb_ff == '0) ? WB_W'(1) : wb_ff;
   assign lam    = (ff_ff == '0) ? FF_W'(1) : ((ff_ff > FF_ONE) ? FF_ONE : ff_ff);

   // shared 33x33 multiplier
   always_comb begin
      mop_a = '0;
      mop_b = '0;
      case (cmd.mul_sel)
         MUL_PP: begin
            mop_a = {2'b0, p_ff};
            mop_b = {2'b0, p_ff};
         end
         MUL_QL_P: begin
            mop_a = {1'b0, q_ff[31:0]};
            mop_b = {1'b0, cov_ff};
         end
         MUL_QH_P: begin
            mop_a = {19'b0, q_ff[Q_W-1:32]};
            mop_b = {1'b0, cov_ff};
         end
         MUL_P_COV: begin
            mop_a = {2'b0, p_ff};
            mop_b = {1'b0, cov_ff};
         end
         MUL_P_A: begin
            mop_a = {2'b0, p_ff};
            mop_b = amag;
         end
         MUL_K0_E0: begin
            mop_a = {1'b0, k_ff[31:0]};
            mop_b = {1'b0, e_ff[31:0]};
         end
         MUL_K0_E1: begin
            mop_a = {1'b0, k_ff[31:0]};
            mop_b = {16'b0, e_ff[E_W-1:32]};
         end
         MUL_K1_E0: begin
            mop_a = {2'b0, k_ff[K_W-1:32]};
            mop_b = {1'b0, e_ff[31:0]};
         end
         MUL_K1_E1: begin
            mop_a = {2'b0, k_ff[K_W-1:32]};
            mop_b = {16'b0, e_ff[E_W-1:32]};
         end
         default: begin
            mop_a = '0;
            mop_b = '0;
         end
      endcase
   end

   // partial product accumulator, shifted by whole 32-bit words
   always_comb begin
      case (cmd.acc_sh)
         SH_W1:   pp_sh = {14'b0, mul_ff, 32'b0};
         SH_W2:   pp_sh = {mul_ff[47:0], 64'b0};
         default: pp_sh = {46'b0, mul_ff};
      endcase
      case (cmd.acc_op)
         ACC_CLR: acc_in = pp_sh;
         ACC_ADD: acc_in = acc_ff + pp_sh;
         default: acc_in = acc_ff;
      endcase
   end

   // divider operands
   always_comb begin
      case (cmd.div_sel)
         DIV_GAIN: begin
            div_dvd = {1'b0, mul_ff[62:0]};
            div_dvs = {1'b0, den_ff};
         end
         DIV_COV: begin
            div_dvd = {16'b0, cov_ff, 16'b0};
            div_dvs = {1'b0, den_ff};
         end
         default: begin
            div_dvd = {16'b0, vmag, 16'b0};
            div_dvs = {33'b0, wb_eff};
         end
      endcase
   end

   srso_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .busy     (div_busy),
      .done     (div_done)
   );

   // denominator: lambda + phi^2 * P (never zero, lambda >= 1)
   assign g      = acc_ff[77:16];
   assign den_in = {1'b0, g} + {46'b0, lam};

   // innovation: yaw_rate - phi * (steer + offset)
   assign a_s    = {steer_u[DATA_W-1], steer_u} + {off_ff[DATA_W-1], off_ff};
   assign amag   = a_s[DATA_W] ? (33'd0 - a_s) : a_s;
   assign t      = mul_ff[63:16];
   assign t_ext  = {2'b0, t};
   assign ts_neg = a_s[DATA_W] ^ vneg;
   assign ts     = ts_neg ? (50'd0 - t_ext) : t_ext;
   assign e_s    = {{18{in_ff.yaw_rate[DATA_W-1]}}, in_ff.yaw_rate} - ts;
   assign e_abs  = e_s[49] ? (50'd0 - e_s) : e_s;

   // offset step: (K * |e|) >> 16, capped at 2^62
   always_comb begin
      if (|acc_ff[ACC_W-1:79]) begin
         d = MID_CAP;
      end else if (acc_ff[78:16] > MID_CAP) begin
         d = MID_CAP;
      end else begin
         d = acc_ff[78:16];
      end
   end

   assign d_ext    = {1'b0, d};
   assign ds       = (eneg_ff ^ vneg) ? (64'd0 - d_ext) : d_ext;
   assign noff     = {{32{off_ff[DATA_W-1]}}, off_ff} + ds;
   assign ovf      = !((&noff[63:31]) || !(|noff[63:31]));
   assign noff_sat = ovf ? (noff[63] ? S32_MIN : S32_MAX) : noff[31:0];

   // configuration and estimator state
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff   <= WB_RST;
         ff_ff   <= FF_RST;
         ms_ff   <= MS_RST;
         mx_ff   <= MX_RST;
         off_ff  <= '0;
         cov_ff  <= ICOV_RST;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_WHEEL_BASE:    wb_ff <= csr_wdata[WB_W-1:0];
               CSR_FORGET_FACTOR: ff_ff <= csr_wdata[FF_W-1:0];
               CSR_MIN_SPEED:     ms_ff <= csr_wdata[MS_W-1:0];
               CSR_MAX_STEER:     mx_ff <= csr_wdata[MX_W-1:0];
               // initial_cov takes effect on the covariance at once
               CSR_INITIAL_COV:   cov_ff <= csr_wdata[COV_W-1:0];
               default: ;
            endcase
         end
         if (cmd.commit && ok_ff) begin
            off_ff <= noff_sat;
            cov_ff <= newp_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) in_ff <= req_payload;
      if (cmd.ld_ok)   ok_ff <= ok;
      if (cmd.ld_p)    p_ff  <= (|div_quo[DIV_W-1:P_W]) ? P_MAX : div_quo[P_W-1:0];
      if (cmd.ld_q)    q_ff  <= mul_ff[61:16];
      if (cmd.ld_den)  den_ff <= den_in;
      if (cmd.ld_k)    k_ff  <= div_quo[K_W-1:0];
      if (cmd.ld_newp) begin
         newp_ff <= (|div_quo[DIV_W-1:COV_W]) ? U32_MAX : div_quo[COV_W-1:0];
      end
      if (cmd.ld_e) begin
         e_ff    <= e_abs[E_W-1:0];
         eneg_ff <= e_s[49];
      end
      if (cmd.commit) begin
         rsp_ff.updated         <= ok_ff;
         rsp_ff.offset_estimate <= ok_ff ? noff_sat : off_ff;
         rsp_ff.covariance_out  <= ok_ff ? newp_ff : cov_ff;
      end
      mul_ff <= mop_a * mop_b;
      acc_ff <= acc_in;
   end

   assign stat.ok       = ok;
   assign stat.div_done = div_done;
   assign stat.div_busy = div_busy;

   assign rsp_payload = rsp_ff;

endmodule

### hw/rtl/srso_ctrl.sv
// Controller: sequences one request through the datapath and owns the response valid.
`timescale 1ns / 1ps

module srso_ctrl import srso_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  srso_stat_type stat,
   output srso_cmd_type  cmd
);

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_CHECK     = 5'd1;
   localparam logic [4:0] ST_WAIT_P    = 5'd2;
   localparam logic [4:0] ST_MUL_Q     = 5'd3;
   localparam logic [4:0] ST_LD_Q      = 5'd4;
   localparam logic [4:0] ST_MUL_G0    = 5'd5;
   localparam logic [4:0] ST_MUL_G1    = 5'd6;
   localparam logic [4:0] ST_ACC_G     = 5'd7;
   localparam logic [4:0] ST_LD_DEN    = 5'd8;
   localparam logic [4:0] ST_START_K   = 5'd9;
   localparam logic [4:0] ST_WAIT_K    = 5'd10;
   localparam logic [4:0] ST_START_COV = 5'd11;
   localparam logic [4:0] ST_WAIT_COV  = 5'd12;
   localparam logic [4:0] ST_MUL_T     = 5'd13;
   localparam logic [4:0] ST_LD_E      = 5'd14;
   localparam logic [4:0] ST_MUL_D0    = 5'd15;
   localparam logic [4:0] ST_MUL_D1    = 5'd16;
   localparam logic [4:0] ST_MUL_D2    = 5'd17;
   localparam logic [4:0] ST_MUL_D3    = 5'd18;
   localparam logic [4:0] ST_ACC_D     = 5'd19;
   localparam logic [4:0] ST_DONE      = 5'd20;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.ld_ok = 1'b1;
            if (stat.ok) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SPEED;
               state_in      = ST_WAIT_P;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WAIT_P: begin
            if (stat.div_done) begin
               cmd.ld_p = 1'b1;
               state_in = ST_MUL_Q;
            end
         end
         ST_MUL_Q: begin
            cmd.mul_sel = MUL_PP;
            state_in    = ST_LD_Q;
         end
         ST_LD_Q: begin
            cmd.ld_q = 1'b1;
            state_in = ST_MUL_G0;
         end
         ST_MUL_G0: begin
            cmd.mul_sel = MUL_QL_P;
            state_in    = ST_MUL_G1;
         end
         ST_MUL_G1: begin
            cmd.acc_op  = ACC_CLR;
            cmd.acc_sh  = SH_W0;
            cmd.mul_sel = MUL_QH_P;
            state_in    = ST_ACC_G;
         end
         ST_ACC_G: begin
            cmd.acc_op = ACC_ADD;
            cmd.acc_sh = SH_W1;
            state_in   = ST_LD_DEN;
         end
         ST_LD_DEN: begin
            cmd.ld_den  = 1'b1;
            cmd.mul_sel = MUL_P_COV;
            state_in    = ST_START_K;
         end
         ST_START_K: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_GAIN;
            state_in      = ST_WAIT_K;
         end
         ST_WAIT_K: begin
            if (stat.div_done) begin
               cmd.ld_k = 1'b1;
               state_in = ST_START_COV;
            end
         end
         ST_START_COV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_COV;
            state_in      = ST_WAIT_COV;
         end
         ST_WAIT_COV: begin
            if (stat.div_done) begin
               cmd.ld_newp = 1'b1;
               state_in    = ST_MUL_T;
            end
         end
         ST_MUL_T: begin
            cmd.mul_sel = MUL_P_A;
            state_in    = ST_LD_E;
         end
         ST_LD_E: begin
            cmd.ld_e = 1'b1;
            state_in = ST_MUL_D0;
         end
         ST_MUL_D0: begin
            cmd.mul_sel = MUL_K0_E0;
            state_in    = ST_MUL_D1;
         end
         ST_MUL_D1: begin
            cmd.acc_op  = ACC_CLR;
            cmd.acc_sh  = SH_W0;
            cmd.mul_sel = MUL_K0_E1;
            state_in    = ST_MUL_D2;
         end
         ST_MUL_D2: begin
            cmd.acc_op  = ACC_ADD;
            cmd.acc_sh  = SH_W1;
            cmd.mul_sel = MUL_K1_E0;
            state_in    = ST_MUL_D3;
         end
         ST_MUL_D3: begin
            cmd.acc_op  = ACC_ADD;
            cmd.acc_sh  = SH_W1;
            cmd.mul_sel = MUL_K1_E1;
            state_in    = ST_ACC_D;
         end
         ST_ACC_D: begin
            cmd.acc_op = ACC_ADD;
            cmd.acc_sh = SH_W2;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.commit)                 rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/scalar_rls_steer_offset_core.sv
// Update tick: three divides in turn (phi, gain, covariance) between request and response.
// Rejected tick (missing samples, slow, or steer over limit) skips the divides and goes to commit.
// Throughput: one request at a time; the next is taken the clock after the response is registered.
// Rate is set by the one-bit-per-clock divider, shared by phi, gain and covariance.
// Reset: synchronous, active high; offset clears, covariance loads the initial_cov default.
`timescale 1ns / 1ps
`include "scalar_rls_steer_offset_core_defines.svh"

module scalar_rls_steer_offset_core import srso_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  srso_req_type          req_payload,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output srso_rsp_type          rsp_payload,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Controller steps one request through:
   //   check -> phi divide -> phi^2 -> phi^2*P -> den -> gain divide
   //   -> covariance divide -> innovation -> K*|e| -> commit.
   // The response register sits in the datapath; the controller can take a
   // new request while an older response still waits, and only holds at
   // commit until the response slot is free.
   srso_cmd_type  cmd;
   srso_stat_type stat;

   srso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: config registers, offset/covariance state, one 33x33
   // multiplier with a 112-bit word-shifted accumulator, and the divider.
   srso_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

   // a new response is never written over one that is still held
   `SRSO_ASSERT(a_commit_slot_free, cmd.commit |-> (!rsp_valid || !rsp_stall), "response overwritten")
   // a committed request shows up on the response port next clock
   `SRSO_ASSERT(a_commit_shows, cmd.commit |=> rsp_valid, "commit without response")
   // the shared divider is never restarted mid-operation
   `SRSO_ASSERT(a_div_start_idle, cmd.div_start |-> !stat.div_busy, "divider restarted while busy")
   // reset leaves no stale response
   `SRSO_ASSERT_RST(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")

endmodule

### verif/tb_scalar_rls_steer_offset_core.sv
// Self-checking testbench for the steering offset estimator core: directed and random ticks against a local RLS model.
`timescale 1ns / 1ps

module tb_scalar_rls_steer_offset_core;
   import srso_pkg::*;

   // Share of cycles in which each side holds off, in percent.
   localparam int          IDLE_PCT        = 18;
   // Clocks with no request or response moving before a hang is declared; far longer than an update tick.
   localparam int          HANG_LIMIT      = 4000;
   localparam int          TAIL_CYCLES     = 250;
   localparam int          PHASES          = 10;
   localparam int          UPDATES_PER_SET = 75;
   localparam int          QUIET_PHASE     = 5;
   localparam logic [63:0] CAP62           = 64'h4000_0000_0000_0000;
   localparam logic [63:0] PHI_SAT         = 64'h7FFF_FFFF;
   localparam logic [31:0] MAG_TOP         = 32'h8000_0000;
   localparam longint      OFFSET_HI       = 64'sd2147483647;
   localparam longint      OFFSET_LO       = -64'sd2147483648;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   srso_req_type          req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   srso_rsp_type          rsp_payload;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_WHEEL_BASE;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   // Local copy of the register file and estimator state, tracked at reset values.
   logic [WB_W-1:0]          cfg_wb     = WB_RST;
   logic [FF_W-1:0]          cfg_ff     = FF_RST;
   logic [MS_W-1:0]          cfg_min    = MS_RST;
   logic [MX_W-1:0]          cfg_max    = MX_RST;
   logic signed [DATA_W-1:0] est_offset = '0;
   logic [DATA_W-1:0]        est_cov    = ICOV_RST;

   srso_req_type tick_q[$];   // requests waiting for the driver
   srso_rsp_type est_q[$];    // predicted estimates, oldest first
   srso_rsp_type est_head;
   int           ticks_fed   = 0;
   int           ticks_taken = 0;
   int           fault_cnt   = 0;
   int           dead_cycles = 0;
   bit           quiet       = 1'b0;

   scalar_rls_steer_offset_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Model of one tick
   // --------------------------------------------------------------------------

   // (x * y) >> F on the full 128-bit product, capped at 2^62.
   function automatic logic [63:0] mul_q16_cap(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] prod;
      prod = ({64'd0, x} * {64'd0, y}) >> FRAC_W;
      return (prod > {64'd0, CAP62}) ? CAP62 : prod[63:0];
   endfunction

   // Runs one tick on the local state and returns the estimate the core should report.
   // All products and quotients work on magnitudes; signs are applied afterwards.
   function automatic srso_rsp_type rls_tick(input srso_req_type r);
      logic [63:0]  vmag, smag, wb, lam, phi, phi_sq, g, den, gain, cov_n;
      logic [63:0]  amag, t, emag, d;
      longint       vel, wz, steer, a, ts, e, ds, sum;
      logic         ok;
      srso_rsp_type res;
      vel   = longint'(r.velocity);
      wz    = longint'(r.yaw_rate);
      steer = longint'(r.steer_angle);
      vmag  = (vel < 0) ? -vel : vel;
      smag  = (steer < 0) ? -steer : steer;
      // gate: both samples present, fast enough, steering inside the window
      ok = r.samples_present && (vmag >= 64'(cfg_min)) && (smag <= 64'(cfg_max));
      if (ok) begin
         // zero wheelbase reads as 1; lambda clamps into [1, one]
         wb  = (cfg_wb == '0) ? 64'd1 : 64'(cfg_wb);
         lam = (cfg_ff == '0) ? 64'd1 : (cfg_ff > FF_ONE) ? 64'(FF_ONE) : 64'(cfg_ff);
         phi = (vmag << FRAC_W) / wb;
         if (phi > PHI_SAT) phi = PHI_SAT;
         phi_sq = (phi * phi) >> FRAC_W;
         g      = mul_q16_cap(phi_sq, 64'(est_cov));
         den    = lam + g;
         if (den == '0) den = 64'd1;
         // gain and new covariance both from the prior covariance
         gain  = (64'(est_cov) * phi) / den;
         cov_n = (64'(est_cov) << FRAC_W) / den;
         if (cov_n > 64'(U32_MAX)) cov_n = 64'(U32_MAX);
         // innovation: yaw rate minus phi * (steer + offset)
         a    = steer + longint'(est_offset);
         amag = (a < 0) ? -a : a;
         t    = (phi * amag) >> FRAC_W;
         ts   = ((a < 0) != (vel < 0)) ? -longint'(t) : longint'(t);
         e    = wz - ts;
         emag = (e < 0) ? -e : e;
         d    = mul_q16_cap(gain, emag);
         ds   = ((e < 0) != (vel < 0)) ? -longint'(d) : longint'(d);
         sum  = longint'(est_offset) + ds;
         if (sum > OFFSET_HI) sum = OFFSET_HI;
         if (sum < OFFSET_LO) sum = OFFSET_LO;
         est_offset = sum[31:0];
         est_cov    = cov_n[31:0];
      end
      res.updated         = ok;
      res.offset_estimate = est_offset;
      res.covariance_out  = est_cov;
      return res;
   endfunction

   // --------------------------------------------------------------------------
   // Request shapes
   // --------------------------------------------------------------------------

   function automatic srso_req_type mk(input logic sp, input logic [31:0] v,
                                       input logic [31:0] y, input logic [31:0] s);
      srso_req_type r;
      r.samples_present = sp;
      r.velocity        = v;
      r.yaw_rate        = y;
      r.steer_angle     = s;
      return r;
   endfunction

   // A tick that passes the gate under the current registers, mostly at vehicle-like scale.
   function automatic srso_req_type good_tick();
      srso_req_type r;
      logic [31:0]  lo, hi, m;
      lo = {1'b0, cfg_min};
      hi = ($urandom_range(3, 0) == 0) ? MAG_TOP : lo + 32'h0040_0000;
      if (hi > MAG_TOP) hi = MAG_TOP;
      m = $urandom_range(hi, lo);
      r.samples_present = 1'b1;
      r.velocity        = $urandom_range(1, 0) ? -m : m;
      hi = {1'b0, cfg_max};
      if ($urandom_range(3, 0) != 0 && hi > 32'h2000) hi = 32'h2000;
      m = $urandom_range(hi, 0);
      r.steer_angle = $urandom_range(1, 0) ? -m : m;
      r.yaw_rate    = $urandom_range(1, 0) ? $urandom : $urandom_range(32'h2_0000, 0) - 32'h1_0000;
      return r;
   endfunction

   // A well-formed tick spoiled in exactly one way, so the gate must reject it.
   function automatic srso_req_type broken_tick();
      srso_req_type r;
      logic [31:0]  m;
      r = good_tick();
      case ($urandom_range(2, 0))
         0: r.samples_present = 1'b0;
         1: begin
            if (cfg_min != '0) begin
               m          = $urandom_range({1'b0, cfg_min} - 1, 0);
               r.velocity = $urandom_range(1, 0) ? -m : m;
            end else begin
               r.samples_present = 1'b0;
            end
         end
         default: begin
            m             = $urandom_range(MAG_TOP, {1'b0, cfg_max} + 1);
            r.steer_angle = $urandom_range(1, 0) ? -m : m;
         end
      endcase
      return r;
   endfunction

   function automatic srso_req_type noise_tick();
      return mk(1'($urandom_range(1, 0)), $urandom, $urandom, $urandom);
   endfunction

   function automatic void feed(input srso_req_type r);
      tick_q.push_back(r);
      ticks_fed++;
   endfunction

   function automatic bit take_break();
      return !quiet && ($urandom_range(99, 0) < IDLE_PCT);
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (fault_cnt < 100) $display("[%0t] %s: got %h expected %h", $time, what, got, want);
      fault_cnt++;
   endtask

   // Register write; the local copy follows at once since nothing is in flight.
   // A write to initial_cov also reloads the covariance.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_WHEEL_BASE:    cfg_wb  = data[WB_W-1:0];
         CSR_FORGET_FACTOR: cfg_ff  = data[FF_W-1:0];
         CSR_MIN_SPEED:     cfg_min = data[MS_W-1:0];
         CSR_MAX_STEER:     cfg_max = data[MX_W-1:0];
         CSR_INITIAL_COV:   est_cov = data;
         default: ;
      endcase
   endtask

   // Every request yields one estimate, so the core is idle once all have come back.
   task automatic drain();
      while (ticks_taken != ticks_fed || est_q.size() != 0) @(negedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Request driver: takes the next tick once the current one is accepted.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            est_q.push_back(rls_tick(req_payload));
            ticks_taken++;
         end
         // payload holds while stalled; only a free slot may change it
         if (!req_valid || !req_stall) begin
            if (tick_q.size() != 0 && !take_break()) begin
               req_valid   <= 1'b1;
               req_payload <= tick_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Response monitor: compares each estimate with the oldest prediction.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (est_q.size() == 0) begin
               flag_mismatch("estimate with no request pending", rsp_payload.offset_estimate,
                             32'd0);
            end else begin
               est_head = est_q.pop_front();
               if (rsp_payload.updated !== est_head.updated)
                  flag_mismatch("updated", 32'(rsp_payload.updated), 32'(est_head.updated));
               if (rsp_payload.offset_estimate !== est_head.offset_estimate)
                  flag_mismatch("offset_estimate", rsp_payload.offset_estimate,
                                est_head.offset_estimate);
               if (rsp_payload.covariance_out !== est_head.covariance_out)
                  flag_mismatch("covariance_out", rsp_payload.covariance_out,
                                est_head.covariance_out);
            end
         end
         rsp_stall <= take_break();
      end
   end

   // Hang detection: no request or response moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         dead_cycles <= 0;
      end else if (dead_cycles >= HANG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         dead_cycles <= dead_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin : stimulus
      int updates;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed ticks at the reset register values.
      feed(mk(1'b1, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000));  // plain update
      feed(mk(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000));  // samples missing
      feed(mk(1'b1, 32'd18677, 32'd100, 32'd0));                     // just under min speed
      feed(mk(1'b1, -32'sd18678, 32'd1000, 32'd0));                  // exactly min speed
      feed(mk(1'b1, 32'd0, 32'd0, 32'd0));                           // standing still
      feed(mk(1'b1, 32'h0002_0000, 32'd500, 32'd3277));              // steer at the limit
      feed(mk(1'b1, 32'h0002_0000, 32'd500, -32'sd3278));            // steer just over
      feed(mk(1'b1, -32'sh0002_0000, -32'sd500, -32'sd3277));
      feed(mk(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0));           // phi saturates
      feed(mk(1'b1, 32'h8000_0000, 32'h8000_0000, 32'd1));
      feed(mk(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      feed(mk(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3277));
      feed(mk(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      feed(mk(1'b1, 32'h000A_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));   // steer at extremes
      feed(mk(1'b1, 32'h000A_0000, 32'd0, 32'h8000_0000));
      feed(mk(1'b0, 32'd0, 32'd0, 32'd0));
      feed(mk(1'b1, 32'h0005_0000, 32'hFFFF_FFFF, -32'sd100));
      feed(mk(1'b1, -32'sh0005_0000, 32'd1, 32'd100));
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               // zero wheelbase and zero lambda, widest gate, covariance at max
               csr_write(CSR_WHEEL_BASE, 32'd0);
               csr_write(CSR_FORGET_FACTOR, 32'd0);
               csr_write(CSR_MIN_SPEED, 32'd0);
               csr_write(CSR_MAX_STEER, 32'h7FFF_FFFF);
               csr_write(CSR_INITIAL_COV, 32'hFFFF_FFFF);
            end
            1: begin
               // largest wheelbase, lambda above one, narrowest gate, zero covariance
               csr_write(CSR_WHEEL_BASE, 32'h7FFF_FFFF);
               csr_write(CSR_FORGET_FACTOR, 32'h0001_FFFF);
               csr_write(CSR_MIN_SPEED, 32'h7FFF_FFFF);
               csr_write(CSR_MAX_STEER, 32'd0);
               csr_write(CSR_INITIAL_COV, 32'd0);
            end
            2: begin
               csr_write(CSR_WHEEL_BASE, 32'd1);
               csr_write(CSR_FORGET_FACTOR, 32'(FF_ONE));
               csr_write(CSR_MIN_SPEED, 32'd0);
               csr_write(CSR_MAX_STEER, 32'h7FFF_FFFF);
               csr_write(CSR_INITIAL_COV, 32'h0001_0000);
            end
            default: begin
               // vehicle-like settings; bits above each register's width are junk
               csr_write(CSR_WHEEL_BASE,
                         $urandom_range(327680, 32768) | ($urandom & 32'h8000_0000));
               csr_write(CSR_FORGET_FACTOR,
                         $urandom_range(65536, 58982) | ($urandom & 32'hFFFE_0000));
               csr_write(CSR_MIN_SPEED,
                         $urandom_range(131072, 0) | ($urandom & 32'h8000_0000));
               csr_write(CSR_MAX_STEER,
                         $urandom_range(65536, 1000) | ($urandom & 32'h8000_0000));
               csr_write(CSR_INITIAL_COV, $urandom);
            end
         endcase
         @(posedge clock);
         csr_we <= 1'b0;
         @(negedge clock);

         // one set runs with no hold-offs on either side
         quiet   = (ph == QUIET_PHASE);
         updates = 0;
         while (updates < UPDATES_PER_SET) begin
            if ($urandom_range(99, 0) < 80) begin
               feed(good_tick());
               updates++;
            end else if ($urandom_range(1, 0) == 1) begin
               feed(noise_tick());
            end else begin
               feed(broken_tick());
            end
         end
         drain();
      end
      quiet = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_cnt == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
